[hdl/shxp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package shxp_pkg;

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} in_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               failed;
	} out_t;

	// classified character, front to back
	typedef struct packed {
		logic       last_char;
		logic       is_space;
		logic       is_sign;
		logic       is_minus;
		logic       is_x;
		logic       is_digit;
		logic       is_zero;
		logic [3:0] digit;
	} cls_t;

	localparam int ClsWidth = $bits(cls_t);
	localparam int OutWidth = $bits(out_t);

	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowF  = 8'h66;
	localparam logic [7:0] ChLowX  = 8'h78;
	localparam logic [7:0] ChUpX   = 8'h58;

endpackage

`default_nettype wire

[hdl/shxp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module shxp_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_wr, do_rd})
				2'b10: begin
					count_q <= count_q + 2'd1;
				end
				2'b01: begin
					count_q <= count_q - 2'd1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/shxp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module shxp_front (
	input  wire shxp_pkg::in_t  item,
	output shxp_pkg::cls_t      cls
);

	import shxp_pkg::*;

	logic is_dec;
	logic is_hex;

	always_comb begin
		is_dec        = (item.character >= ChZero) && (item.character <= ChNine);
		is_hex        = (item.character >= ChLowA) && (item.character <= ChLowF);
		cls.last_char = item.last_char;
		cls.is_space  = (item.character == ChSpace);
		cls.is_minus  = (item.character == ChMinus);
		cls.is_sign   = (item.character == ChPlus) || (item.character == ChMinus);
		cls.is_x      = (item.character == ChLowX) || (item.character == ChUpX);
		cls.is_digit  = is_dec || is_hex;
		cls.is_zero   = (item.character == ChZero);
		if (is_hex) begin
			cls.digit = 4'(item.character - ChLowA + 8'd10);
		end else begin
			cls.digit = item.character[3:0];
		end
	end

endmodule

`default_nettype wire

[hdl/shxp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module shxp_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire shxp_pkg::cls_t  cls,
	input  wire logic            cls_empty,
	output logic                 cls_pop,
	input  wire logic            res_full,
	output logic                 res_push,
	output shxp_pkg::out_t       res
);

	import shxp_pkg::*;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_FIRST  = 3'd1;
	localparam logic [2:0] PH_SECOND = 3'd2;
	localparam logic [2:0] PH_PREFIX = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	logic [2:0]             phase_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic                   neg_q;
	logic                   err_q;

	logic [2:0]             phase_n;
	logic [VALUE_WIDTH-1:0] acc_n;
	logic                   neg_n;
	logic                   err_n;
	logic [VALUE_WIDTH-1:0] digit_ext;
	logic [VALUE_WIDTH-1:0] shifted;
	logic [VALUE_WIDTH-1:0] signed_val;
	logic [63:0]            val_ext;
	logic                   bad;

	assign cls_pop  = !cls_empty && (!cls.last_char || !res_full);
	assign res_push = cls_pop && cls.last_char;

	always_comb begin
		digit_ext = {{(VALUE_WIDTH-4){1'b0}}, cls.digit};
		shifted   = {acc_q[VALUE_WIDTH-5:0], cls.digit};
		phase_n   = phase_q;
		acc_n     = acc_q;
		neg_n     = neg_q;
		err_n     = err_q;
		if (!err_q) begin
			unique case (phase_q)
				PH_START, PH_FIRST: begin
					if (phase_q == PH_START && cls.is_space) begin
						phase_n = phase_q;
					end else if (phase_q == PH_START && cls.is_sign) begin
						neg_n   = cls.is_minus;
						phase_n = PH_FIRST;
					end else if (!cls.is_digit) begin
						err_n = 1'b1;
					end else begin
						acc_n   = digit_ext;
						phase_n = cls.is_zero ? PH_SECOND : PH_DIGITS;
					end
				end
				PH_SECOND: begin
					if (cls.is_x) begin
						phase_n = PH_PREFIX;
					end else if (!cls.is_digit) begin
						err_n = 1'b1;
					end else begin
						acc_n   = shifted;
						phase_n = PH_DIGITS;
					end
				end
				PH_PREFIX: begin
					if (!cls.is_digit) begin
						err_n = 1'b1;
					end else begin
						acc_n   = digit_ext;
						phase_n = PH_DIGITS;
					end
				end
				PH_DIGITS: begin
					if (!cls.is_digit) begin
						err_n = 1'b1;
					end else begin
						acc_n = shifted;
					end
				end
				default: begin
					err_n = 1'b1;
				end
			endcase
		end
		bad        = err_n || !(phase_n == PH_SECOND || phase_n == PH_DIGITS);
		signed_val = neg_n ? (VALUE_WIDTH'(0) - acc_n) : acc_n;
		val_ext    = 64'(signed_val);
		res.failed = bad;
		res.value  = bad ? 32'sd0 : signed'(val_ext[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (cls_pop) begin
			if (cls.last_char) begin
				phase_q <= PH_START;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/signed_hex_string_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Signed hex string parser: one character per beat, one result beat per string, given on
// the beat whose last_char is set. Sustains one character per clock but for the stall below.
// A character is registered in the two-entry character queue and is parsed combinationally
// against the running value of VALUE_WIDTH bits as it leaves; a string's result is registered in
// the two-entry result queue, from which it is popped. While that queue holds two results,
// the character that ends the next string stalls and the character queue fills behind it.
module signed_hex_string_parser_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire shxp_pkg::in_t   item,
	output logic                 empty,
	input  wire logic            pop,
	output shxp_pkg::out_t       result
);

	import shxp_pkg::*;

	cls_t                cls_in;
	cls_t                cls_out;
	logic [ClsWidth-1:0] cls_rd;
	logic                cls_empty;
	logic                cls_pop;
	logic                res_full;
	logic                res_push;
	out_t                res_in;
	logic [OutWidth-1:0] res_rd;

	shxp_front u_front (
		.item (item),
		.cls  (cls_in)
	);

	shxp_fifo #(
		.WIDTH (ClsWidth)
	) u_cls_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls_in),
		.full    (full),
		.rd_en   (cls_pop),
		.rd_data (cls_rd),
		.empty   (cls_empty)
	);

	assign cls_out = cls_t'(cls_rd);

	shxp_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_out),
		.cls_empty (cls_empty),
		.cls_pop   (cls_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	shxp_fifo #(
		.WIDTH (OutWidth)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign result = out_t'(res_rd);

endmodule

`default_nettype wire

[hdl/shxp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module shxp_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire logic            full,
	input  wire shxp_pkg::in_t   item,
	input  wire logic            empty,
	input  wire logic            pop,
	input  wire shxp_pkg::out_t  result
);

	// failed results carry a zero value
	a_failed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.failed |-> result.value == 32'sd0)
		else $error("failed result with nonzero value");

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result beat changed while stalled");

	// stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |=> push && $stable(item))
		else $error("input beat changed while stalled");

	// full only rises behind an offered beat
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !push |=> !full)
		else $error("full rose with no beat offered");

	// queues come up empty out of reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("queues not empty after reset");

endmodule

bind signed_hex_string_parser_unit shxp_checker u_shxp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire

[bench/signed_hex_string_parser_unit_tb.sv]
`timescale 1ns / 1ps

module signed_hex_string_parser_unit_tb;
	import shxp_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int LongHold   = 300;

	typedef enum logic [2:0] {
		ScanLead,
		ScanFirst,
		ScanAfterZero,
		ScanAfterPrefix,
		ScanDigits
	} scan_e;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic push   = 1'b0;
	logic pop    = 1'b0;
	in_t  item   = '0;
	logic full;
	logic empty;
	out_t result;

	signed_hex_string_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #4 clk = ~clk;

	in_t        char_queue[$];
	out_t       want_results[$];
	logic [7:0] str_buf[$];

	// parser state as predicted
	scan_e       scan      = ScanLead;
	logic [31:0] acc       = '0;
	logic        minus_seen = 1'b0;
	logic        bad_seen  = 1'b0;

	int mismatches     = 0;
	int results_seen   = 0;
	int strings_total  = 0;
	int strings_failed = 0;
	int total_chars    = 0;
	int long_holds     = 0;
	int cycle_count    = 0;

	function automatic int digit_of(logic [7:0] c);
		if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
		if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(int d);
		return (d < 10) ? ChZero + 8'(d) : ChLowA + 8'(d - 10);
	endfunction

	task automatic parse_char(in_t it);
		logic [7:0] c;
		int         d;
		logic       bad;
		out_t       want;
		c = it.character;
		d = digit_of(c);
		if (!bad_seen) begin
			case (scan)
				ScanLead: begin
					if (c == ChSpace) begin
					end else if (c == ChPlus || c == ChMinus) begin
						minus_seen = (c == ChMinus);
						scan = ScanFirst;
					end else if (d < 0) begin
						bad_seen = 1'b1;
					end else begin
						acc = 32'(d);
						scan = (c == ChZero) ? ScanAfterZero : ScanDigits;
					end
				end
				ScanFirst: begin
					if (d < 0) bad_seen = 1'b1;
					else begin
						acc = 32'(d);
						scan = (c == ChZero) ? ScanAfterZero : ScanDigits;
					end
				end
				ScanAfterZero: begin
					if (c == ChLowX || c == ChUpX) scan = ScanAfterPrefix;
					else if (d < 0) bad_seen = 1'b1;
					else begin
						acc = {acc[27:0], 4'(d)};
						scan = ScanDigits;
					end
				end
				ScanAfterPrefix: begin
					if (d < 0) bad_seen = 1'b1;
					else begin
						acc = 32'(d);
						scan = ScanDigits;
					end
				end
				ScanDigits: begin
					if (d < 0) bad_seen = 1'b1;
					else acc = {acc[27:0], 4'(d)};
				end
				default: bad_seen = 1'b1;
			endcase
		end
		if (it.last_char) begin
			bad = bad_seen || !(scan == ScanAfterZero || scan == ScanDigits);
			want.failed = bad;
			want.value = bad ? 32'sd0 : (minus_seen ? -acc : acc);
			want_results.push_back(want);
			strings_total++;
			if (bad) strings_failed++;
			scan = ScanLead;
			acc = '0;
			minus_seen = 1'b0;
			bad_seen = 1'b0;
		end
	endtask

	task automatic check_result(out_t got);
		out_t want;
		if (want_results.size() == 0) begin
			$display("%0t: result with nothing pending, value %h failed %b",
				$time, got.value, got.failed);
			mismatches++;
		end else begin
			want = want_results.pop_front();
			if (got.value !== want.value) begin
				$display("%0t: value expected %h actual %h", $time, want.value, got.value);
				mismatches++;
			end
			if (got.failed !== want.failed) begin
				$display("%0t: failed expected %b actual %b", $time, want.failed, got.failed);
				mismatches++;
			end
		end
		results_seen++;
	endtask

	task automatic flush_string();
		in_t it;
		for (int i = 0; i < str_buf.size(); i++) begin
			it.character = str_buf[i];
			it.last_char = (i == str_buf.size() - 1);
			char_queue.push_back(it);
		end
		str_buf.delete();
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
		flush_string();
	endtask

	task automatic build_random_string();
		int kind;
		int n;
		int pos;
		kind = $urandom_range(0, 99);
		if (kind >= 92) begin
			// pure noise
			repeat ($urandom_range(1, 6)) str_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) str_buf.push_back(ChSpace);
			if ($urandom_range(0, 2) == 0)
				str_buf.push_back($urandom_range(0, 1) ? ChMinus : ChPlus);
			if ($urandom_range(0, 3) == 0) begin
				str_buf.push_back(ChZero);
				str_buf.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
			end
			n = (kind < 6) ? 0 : $urandom_range(1, 10);
			repeat (n) begin
				if ($urandom_range(0, 7) == 0) str_buf.push_back(ChZero);
				else str_buf.push_back(hex_char($urandom_range(0, 15)));
			end
			if (kind >= 78) begin
				pos = $urandom_range(0, str_buf.size());
				str_buf.insert(pos, 8'($urandom_range(0, 255)));
			end
			if (str_buf.size() == 0) str_buf.push_back(ChSpace);
		end
		flush_string();
	endtask

	// driver: bursts with random gaps
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (push && !full) parse_char(item);
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (char_queue.size() != 0) begin
					item <= char_queue.pop_front();
					push <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: pop pattern changes on a timer, plus long hold-offs
	int pop_mode   = 0;
	int mode_timer = 0;
	int hold_left  = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold_left = 0;
			mode_timer = 0;
		end else begin
			if (pop && !empty) check_result(result);
			mode_timer++;
			if (mode_timer == 50) begin
				mode_timer = 0;
				pop_mode = $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if ((results_seen == 15 && long_holds == 0) ||
					(results_seen == 60 && long_holds == 1)) begin
				hold_left = LongHold;
				long_holds++;
				pop <= 1'b0;
			end else begin
				case (pop_mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 1) == 1);
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("%0t: timeout, %0d results still pending", $time, want_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		// directed strings
		add_text("0");
		add_text("-0x");
		add_text(" +");
		add_text("0Xf");
		add_text("-1");
		add_text("A");
		str_buf.push_back(8'hff);
		flush_string();
		add_text("1 2");
		add_text("--");
		add_text(" ");
		add_text("f00000001");
		while (char_queue.size() < 760) build_random_string();
		total_chars = char_queue.size();

		repeat (8) @(posedge clk);
		arst_n = 1'b1;

		while (char_queue.size() != 0 || push) @(posedge clk);
		while (want_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d characters in %0d strings: %0d parsed, %0d malformed",
			total_chars, strings_total, strings_total - strings_failed, strings_failed);
		$display("receiver held off %0d times for %0d cycles with the input pushing",
			long_holds, LongHold);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
